// File: rtl/tvns_pkg.sv
// Shared types, codes and helper functions for the three-valued netlist settler.
// No dependencies; the datapath, controller and top level import this package.
package tvns_pkg;

  // Command codes
  localparam logic [2:0] CMD_CLEAR      = 3'd0;
  localparam logic [2:0] CMD_ADD        = 3'd1;
  localparam logic [2:0] CMD_CONNECT    = 3'd2;
  localparam logic [2:0] CMD_DISCONNECT = 3'd3;
  localparam logic [2:0] CMD_EVAL       = 3'd4;
  localparam logic [2:0] CMD_TRACE      = 3'd5;
  localparam logic [2:0] CMD_TRACE_FROM = 3'd6;

  // Gate kinds
  localparam logic [3:0] KIND_IN   = 4'd0;
  localparam logic [3:0] KIND_OUT  = 4'd1;
  localparam logic [3:0] KIND_AND  = 4'd2;
  localparam logic [3:0] KIND_OR   = 4'd3;
  localparam logic [3:0] KIND_NOT  = 4'd4;
  localparam logic [3:0] KIND_NAND = 4'd5;
  localparam logic [3:0] KIND_NOR  = 4'd6;
  localparam logic [3:0] KIND_XOR  = 4'd7;
  localparam logic [3:0] KIND_XNOR = 4'd8;
  localparam logic [3:0] KIND_BUF  = 4'd9;
  localparam logic [3:0] KIND_ZERO = 4'd10;
  localparam logic [3:0] KIND_ONE  = 4'd11;

  // Node levels
  localparam logic [1:0] LVL_ZERO = 2'd0;
  localparam logic [1:0] LVL_ONE  = 2'd1;
  localparam logic [1:0] LVL_X    = 2'd2;

  // Pin source encoding: an unconnected pin never matches a live node
  localparam int         SRC_W    = 6;
  localparam logic [5:0] SRC_NONE = 6'h20;

  // Datapath operations
  localparam logic [3:0] OP_NONE        = 4'd0;
  localparam logic [3:0] OP_CLEAR       = 4'd1;
  localparam logic [3:0] OP_ADD         = 4'd2;
  localparam logic [3:0] OP_CONNECT     = 4'd3;
  localparam logic [3:0] OP_DISCONNECT  = 4'd4;
  localparam logic [3:0] OP_START_A     = 4'd5;
  localparam logic [3:0] OP_START_B     = 4'd6;
  localparam logic [3:0] OP_DRIVE       = 4'd7;
  localparam logic [3:0] OP_SWEEP       = 4'd8;
  localparam logic [3:0] OP_SWEEP_COUNT = 4'd9;
  localparam logic [3:0] OP_CLR_CNT     = 4'd10;

  typedef struct packed {
    logic       take;        // open the request channel
    logic [3:0] op;
    logic       emit;        // load the result register
    logic       emit_masks;  // result carries level masks
    logic       emit_stable;
    logic       emit_glitch;
    logic       emit_last;
    logic [5:0] step;
    logic [5:0] settled;
  } dp_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] cmd;
    logic       next_stable;
    logic       drive_done;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [1:0] default_pins(input logic [3:0] kind);
    logic [1:0] n;
    case (kind)
      KIND_IN, KIND_ZERO, KIND_ONE: n = 2'd0;
      KIND_OUT, KIND_NOT, KIND_BUF: n = 2'd1;
      default:                      n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic is_variadic(input logic [3:0] kind);
    return kind == KIND_AND || kind == KIND_OR || kind == KIND_NAND ||
           kind == KIND_NOR || kind == KIND_XOR || kind == KIND_XNOR;
  endfunction

  // Resolve one gate from pin summary flags; controlling values win over unknowns
  function automatic logic [1:0] gate_level(input logic [3:0] kind, input logic any0,
                                            input logic any1, input logic anyx,
                                            input logic par);
    logic [1:0] r;
    case (kind)
      KIND_ZERO:          r = LVL_ZERO;
      KIND_ONE:           r = LVL_ONE;
      KIND_OUT, KIND_BUF: r = anyx ? LVL_X : (any1 ? LVL_ONE : LVL_ZERO);
      KIND_NOT:           r = anyx ? LVL_X : (any1 ? LVL_ZERO : LVL_ONE);
      KIND_AND:           r = any0 ? LVL_ZERO : (anyx ? LVL_X : LVL_ONE);
      KIND_NAND:          r = any0 ? LVL_ONE : (anyx ? LVL_X : LVL_ZERO);
      KIND_OR:            r = any1 ? LVL_ONE : (anyx ? LVL_X : LVL_ZERO);
      KIND_NOR:           r = any1 ? LVL_ZERO : (anyx ? LVL_X : LVL_ONE);
      KIND_XOR:           r = anyx ? LVL_X : {1'b0, par};
      KIND_XNOR:          r = anyx ? LVL_X : {1'b0, ~par};
      default:            r = LVL_X;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tvns_req_if.sv
// Request channel: valid/ready handshake carrying one command beat.
// No dependencies.
interface tvns_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [4:0]  node;
  logic [3:0]  gate_kind;
  logic [3:0]  pin;
  logic [4:0]  source_node;
  logic [31:0] mask_a;
  logic [31:0] mask_b;

  modport source(output valid, cmd, node, gate_kind, pin, source_node, mask_a, mask_b,
                 input ready);
  modport sink(input valid, cmd, node, gate_kind, pin, source_node, mask_a, mask_b,
               output ready);
endinterface

// File: rtl/tvns_rsp_if.sv
// Result channel: valid/ready handshake carrying one result beat.
// No dependencies.
interface tvns_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [4:0]  node_index;
  logic [31:0] known_mask;
  logic [31:0] value_mask;
  logic [5:0]  step_index;
  logic [5:0]  settled_count;
  logic        stable;
  logic [31:0] glitch_mask;
  logic        last;

  modport source(output valid, ok, node_index, known_mask, value_mask, step_index,
                 settled_count, stable, glitch_mask, last, input ready);
  modport sink(input valid, ok, node_index, known_mask, value_mask, step_index,
               settled_count, stable, glitch_mask, last, output ready);
endinterface

// File: rtl/tvns_datapath.sv
// Datapath: netlist tables, node levels, parallel sweep logic and result register.
// Depends on tvns_pkg, tvns_req_if and tvns_rsp_if.
module tvns_datapath #(
  parameter int NODES     = 32,
  parameter int MAX_FANIN = 8
) (
  input  logic              clk,
  input  logic              rst,
  tvns_req_if.sink          req,
  tvns_rsp_if.source        rsp,
  input  tvns_pkg::dp_cmd_t cmd,
  output tvns_pkg::dp_stat_t stat
);
  import tvns_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int GW = $clog2(NODES + 1);
  localparam int CW = $clog2(MAX_FANIN + 1);

  // Captured command beat
  logic [2:0]  cmd_q;
  logic [4:0]  node_q;
  logic [3:0]  kind_q;
  logic [3:0]  pin_q;
  logic [4:0]  src_q;
  logic [31:0] ma_q;
  logic [31:0] mb_q;

  // Netlist store
  logic [3:0]       kind_tab [NODES];
  logic [CW-1:0]    cnt_tab  [NODES];
  logic [SRC_W-1:0] src_tab  [NODES][MAX_FANIN];
  logic [GW-1:0]    gt;
  logic [GW-1:0]    n_in;

  // Simulation state
  logic [1:0]  lvl [NODES];
  logic [1:0]  chg [NODES];
  logic [GW-1:0] walk;
  logic [4:0]  ptr;
  logic [31:0] drv_mask;

  // Result register
  logic        out_valid;
  logic        out_ok;
  logic [4:0]  out_idx;
  logic [31:0] out_known;
  logic [31:0] out_value;
  logic [5:0]  out_step;
  logic [5:0]  out_settled;
  logic        out_stable;
  logic [31:0] out_glitch;
  logic        out_last;

  logic          accept;
  logic          out_free;
  logic [NW-1:0] node_ix;
  logic [NW-1:0] gt_ix;
  logic [NW-1:0] walk_ix;
  logic          node_live;
  logic          src_live;
  logic          pin_lt_cnt;
  logic          pin_lt_max;
  logic          add_ok;
  logic          con_ok;
  logic          disc_ok;
  logic          simple_ok;
  logic [1:0]    nxt [NODES];
  logic [NODES-1:0] moved;
  logic [31:0]   known_m;
  logic [31:0]   value_m;
  logic [31:0]   glitch_m;

  // Handshakes; take nothing while in reset
  assign accept    = req.valid && req.ready;
  assign req.ready = cmd.take && !rst;
  assign out_free  = !out_valid || rsp.ready;

  // Command checks on the captured beat
  assign node_ix    = node_q[NW-1:0];
  assign gt_ix      = gt[NW-1:0];
  assign walk_ix    = walk[NW-1:0];
  assign node_live  = 6'(node_q) < 6'(gt);
  assign src_live   = 6'(src_q) < 6'(gt);
  assign pin_lt_cnt = 5'(pin_q) < 5'(cnt_tab[node_ix]);
  assign pin_lt_max = 5'(pin_q) < 5'(MAX_FANIN);
  assign add_ok     = (6'(gt) < 6'(NODES)) && (kind_q <= KIND_ONE);
  assign con_ok     = src_live && node_live && (src_q != node_q) &&
                      (default_pins(kind_tab[node_ix]) != 2'd0) &&
                      (pin_lt_cnt || (is_variadic(kind_tab[node_ix]) && pin_lt_max));
  assign disc_ok    = node_live && pin_lt_cnt && pin_lt_max;

  always_comb begin
    case (cmd_q)
      CMD_CLEAR:      simple_ok = 1'b1;
      CMD_ADD:        simple_ok = add_ok;
      CMD_CONNECT:    simple_ok = con_ok;
      CMD_DISCONNECT: simple_ok = disc_ok;
      default:        simple_ok = 1'b0;
    endcase
  end

  // Evaluate every live non-input node from the current level vector
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      logic any0, any1, anyx, par;
      logic [1:0] b;
      logic [SRC_W-1:0] s;
      any0 = 1'b0;
      any1 = 1'b0;
      anyx = 1'b0;
      par  = 1'b0;
      for (int p = 0; p < MAX_FANIN; p++) begin
        s = src_tab[i][p];
        b = (s < 6'(gt)) ? lvl[s[NW-1:0]] : LVL_X;
        if (5'(p) < 5'(cnt_tab[i])) begin
          if (b >= LVL_X) anyx = 1'b1;
          else if (b == LVL_ONE) begin
            any1 = 1'b1;
            par  = ~par;
          end else any0 = 1'b1;
        end
      end
      if ((6'(i) < 6'(gt)) && (kind_tab[i] != KIND_IN))
        nxt[i] = gate_level(kind_tab[i], any0, any1, anyx, par);
      else
        nxt[i] = lvl[i];
      moved[i] = nxt[i] != lvl[i];
    end
  end

  // Form level and glitch masks over live nodes
  always_comb begin
    known_m  = '0;
    value_m  = '0;
    glitch_m = '0;
    for (int i = 0; i < NODES; i++) begin
      if (6'(i) < 6'(gt)) begin
        known_m[i]  = lvl[i] < LVL_X;
        value_m[i]  = lvl[i] == LVL_ONE;
        glitch_m[i] = chg[i] > 2'd1;
      end
    end
  end

  assign stat.accepted    = accept;
  assign stat.cmd         = cmd_q;
  assign stat.next_stable = ~|moved;
  assign stat.drive_done  = walk == gt;
  assign stat.out_free    = out_free;

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.cmd;
      node_q <= req.node;
      kind_q <= req.gate_kind;
      pin_q  <= req.pin;
      src_q  <= req.source_node;
      ma_q   <= req.mask_a;
      mb_q   <= req.mask_b;
    end
  end

  // Write the netlist tables
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ADD && add_ok) begin
      kind_tab[gt_ix] <= kind_q;
      cnt_tab[gt_ix]  <= CW'(default_pins(kind_q));
      for (int p = 0; p < MAX_FANIN; p++) src_tab[gt_ix][p] <= SRC_NONE;
    end
    if (cmd.op == OP_CONNECT && con_ok) begin
      if (!pin_lt_cnt) cnt_tab[node_ix] <= CW'({1'b0, pin_q} + 5'd1);
      for (int p = 0; p < MAX_FANIN; p++) begin
        if (5'(p) == 5'(pin_q))
          src_tab[node_ix][p] <= {1'b0, src_q};
        else if (5'(p) >= 5'(cnt_tab[node_ix]) && 5'(p) < 5'(pin_q))
          src_tab[node_ix][p] <= SRC_NONE;
      end
    end
    if (cmd.op == OP_DISCONNECT && disc_ok) begin
      for (int p = 0; p < MAX_FANIN; p++)
        if (5'(p) == 5'(pin_q)) src_tab[node_ix][p] <= SRC_NONE;
    end
  end

  // Node levels, change counters, input drive walk
  always_ff @(posedge clk) begin
    if (rst) begin
      gt   <= '0;
      n_in <= '0;
      walk <= '0;
      for (int i = 0; i < NODES; i++) begin
        lvl[i] <= LVL_X;
        chg[i] <= 2'd0;
      end
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          gt   <= '0;
          n_in <= '0;
          for (int i = 0; i < NODES; i++) lvl[i] <= LVL_X;
        end
        OP_ADD: begin
          if (add_ok) begin
            lvl[gt_ix] <= LVL_X;
            gt <= gt + GW'(1);
            if (kind_q == KIND_IN) n_in <= n_in + GW'(1);
          end
        end
        OP_START_A: begin
          for (int i = 0; i < NODES; i++) lvl[i] <= LVL_X;
          walk     <= '0;
          ptr      <= 5'(n_in - GW'(1));
          drv_mask <= ma_q;
        end
        OP_START_B: begin
          walk     <= '0;
          ptr      <= 5'(n_in - GW'(1));
          drv_mask <= mb_q;
        end
        OP_DRIVE: begin
          if (walk != gt) begin
            if (kind_tab[walk_ix] == KIND_IN) begin
              lvl[walk_ix] <= {1'b0, drv_mask[ptr]};
              ptr <= ptr - 5'd1;
            end
            walk <= walk + GW'(1);
          end
        end
        OP_SWEEP: begin
          for (int i = 0; i < NODES; i++) lvl[i] <= nxt[i];
        end
        OP_SWEEP_COUNT: begin
          for (int i = 0; i < NODES; i++) begin
            lvl[i] <= nxt[i];
            if (lvl[i] < LVL_X && nxt[i] < LVL_X && moved[i] && chg[i] != 2'd3)
              chg[i] <= chg[i] + 2'd1;
          end
        end
        OP_CLR_CNT: begin
          for (int i = 0; i < NODES; i++) chg[i] <= 2'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: drop on take, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ok      <= cmd.emit_masks ? 1'b1 : simple_ok;
      out_idx     <= (cmd_q == CMD_ADD && add_ok && !cmd.emit_masks) ? 5'(gt) : 5'd0;
      out_known   <= cmd.emit_masks ? known_m : 32'd0;
      out_value   <= cmd.emit_masks ? value_m : 32'd0;
      out_step    <= cmd.step;
      out_settled <= cmd.settled;
      out_stable  <= cmd.emit_stable;
      out_glitch  <= cmd.emit_glitch ? glitch_m : 32'd0;
      out_last    <= cmd.emit_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.ok            = out_ok;
  assign rsp.node_index    = out_idx;
  assign rsp.known_mask    = out_known;
  assign rsp.value_mask    = out_value;
  assign rsp.step_index    = out_step;
  assign rsp.settled_count = out_settled;
  assign rsp.stable        = out_stable;
  assign rsp.glitch_mask   = out_glitch;
  assign rsp.last          = out_last;

endmodule

// File: rtl/tvns_ctrl.sv
// Controller: sequences command decode, input drive, settling sweeps and trace beats.
// Depends on tvns_pkg.
module tvns_ctrl #(
  parameter int MAX_SWEEPS = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  tvns_pkg::dp_stat_t stat,
  output tvns_pkg::dp_cmd_t  cmd
);
  import tvns_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_SIMPLE    = 4'd2;
  localparam logic [3:0] S_DRIVE     = 4'd3;
  localparam logic [3:0] S_SETTLE    = 4'd4;
  localparam logic [3:0] S_RESTART   = 4'd5;
  localparam logic [3:0] S_EVAL_OUT  = 4'd6;
  localparam logic [3:0] S_REC_START = 4'd7;
  localparam logic [3:0] S_REC_OUT   = 4'd8;

  logic [3:0] state, state_next;
  logic [5:0] sweeps, sweeps_next;
  logic       phase, phase_next;
  logic       stable_r, stable_r_next;
  logic       at_lim;
  logic       fin;

  assign at_lim = sweeps == 6'(MAX_SWEEPS);
  assign fin    = at_lim || stat.next_stable;

  always_comb begin
    state_next    = state;
    sweeps_next   = sweeps;
    phase_next    = phase;
    stable_r_next = stable_r;
    cmd           = '0;
    cmd.op        = OP_NONE;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (stat.accepted) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.cmd == CMD_EVAL || stat.cmd == CMD_TRACE || stat.cmd == CMD_TRACE_FROM) begin
          cmd.op     = OP_START_A;
          phase_next = 1'b0;
          state_next = S_DRIVE;
        end else begin
          state_next = S_SIMPLE;
        end
      end
      // Execute table commands together with their single result beat
      S_SIMPLE: begin
        if (stat.out_free) begin
          case (stat.cmd)
            CMD_CLEAR:      cmd.op = OP_CLEAR;
            CMD_ADD:        cmd.op = OP_ADD;
            CMD_CONNECT:    cmd.op = OP_CONNECT;
            CMD_DISCONNECT: cmd.op = OP_DISCONNECT;
            default:        cmd.op = OP_NONE;
          endcase
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DRIVE: begin
        if (stat.drive_done) begin
          sweeps_next = '0;
          if (stat.cmd == CMD_TRACE || (stat.cmd == CMD_TRACE_FROM && phase))
            state_next = S_REC_START;
          else
            state_next = S_SETTLE;
        end else begin
          cmd.op = OP_DRIVE;
        end
      end
      // Sweep until nothing moves or the sweep limit is hit
      S_SETTLE: begin
        if (stat.next_stable) begin
          stable_r_next = 1'b1;
          state_next    = (stat.cmd == CMD_EVAL) ? S_EVAL_OUT : S_RESTART;
        end else begin
          cmd.op      = OP_SWEEP;
          sweeps_next = sweeps + 6'd1;
          if (sweeps == 6'(MAX_SWEEPS - 1)) begin
            stable_r_next = 1'b0;
            state_next    = (stat.cmd == CMD_EVAL) ? S_EVAL_OUT : S_RESTART;
          end
        end
      end
      S_RESTART: begin
        cmd.op     = OP_START_B;
        phase_next = 1'b1;
        state_next = S_DRIVE;
      end
      S_EVAL_OUT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_masks  = 1'b1;
          cmd.emit_stable = stable_r;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_REC_START: begin
        cmd.op      = OP_CLR_CNT;
        sweeps_next = '0;
        state_next  = S_REC_OUT;
      end
      // Emit the current step; advance one counted sweep unless this is the final beat
      S_REC_OUT: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_masks = 1'b1;
          cmd.step       = sweeps;
          if (fin) begin
            cmd.emit_last   = 1'b1;
            cmd.emit_stable = !at_lim;
            cmd.emit_glitch = 1'b1;
            cmd.settled     = sweeps;
            state_next      = S_IDLE;
          end else begin
            cmd.op      = OP_SWEEP_COUNT;
            sweeps_next = sweeps + 6'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sweeps   <= '0;
      phase    <= 1'b0;
      stable_r <= 1'b0;
    end else begin
      state    <= state_next;
      sweeps   <= sweeps_next;
      phase    <= phase_next;
      stable_r <= stable_r_next;
    end
  end

endmodule

// File: rtl/three_valued_netlist_settler.sv
// Top level of the three-valued netlist settler: controller plus datapath.
// Depends on tvns_pkg, tvns_req_if, tvns_rsp_if, tvns_datapath and tvns_ctrl.
//
// Usage: commands arrive as beats on req (valid/ready); results leave as beats
// on rsp (valid/ready), each command giving one beat except traces, which give
// one beat per recorded step with last set on the final one.
// Sequence: each accepted command is decoded first; clear, add, connect,
// disconnect and an unknown command then load their single result.
// Evaluate sets all levels unknown, drives the inputs from mask_a (the drive
// walks one node per cycle over all G gates) and then sweeps (all nodes in one
// cycle per sweep, at most MAX_SWEEPS) until nothing moves, then loads its result.
// A trace drives the inputs, then emits one beat per cycle while rsp is not stalled;
// trace from first settles after driving mask_a, then drives mask_b and records.
// Throughput: one command at a time; req.ready is high only while idle.
// The result register parts the channels: a new command is accepted while the
// previous final beat still waits, and while rsp is stalled the controller
// holds at the next beat without losing any state.
// Reset (rst, synchronous): empties the netlist, sets all levels unknown and
// drops any pending result; req.ready stays low while rst is high.
module three_valued_netlist_settler #(
  parameter int NODES      = 32,
  parameter int MAX_FANIN  = 8,
  parameter int MAX_SWEEPS = 63
) (
  input logic        clk,
  input logic        rst,
  tvns_req_if.sink   req,
  tvns_rsp_if.source rsp
);
  import tvns_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tvns_ctrl #(
    .MAX_SWEEPS(MAX_SWEEPS)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  tvns_datapath #(
    .NODES    (NODES),
    .MAX_FANIN(MAX_FANIN)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .stat(stat)
  );

endmodule
